/* rtl/core/rfda_pkg.sv */
// Shared types and constants for the fractional-delay impulse accumulator.
// Holds item kinds, back-end command format and sequencer states.
// No dependencies.
package rfda_pkg;

	localparam int RESPONSE_LEN_DEF = 16384;
	localparam int FILTER_LEN_DEF   = 81;
	localparam int LUT_STEPS_DEF    = 20;

	localparam int RATE_W   = 18;
	localparam int TIME_W   = 32;
	localparam int ATT_W    = 20;
	localparam int IDX_W    = 14;
	localparam int VALUE_W  = 32;
	localparam int FRAC_W   = 28;
	localparam int POS_W    = 9;
	localparam int BASE_W   = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd16000;
	localparam longint PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_READ,
		OP_CLEAR,
		OP_REJECT,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [BASE_W-1:0]        base;
		logic [POS_W-1:0]         pos;
		logic [FRAC_W-1:0]        wt;
		logic signed [ATT_W-1:0]  att;
		logic [IDX_W-1:0]         idx;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_TAPS,
		ST_DRAIN,
		ST_READ,
		ST_RDWAIT,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/rfda_if.sv */
// Valid/ready channel interfaces for source items and results.
// Depends on rfda_pkg for field widths.
interface rfda_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          kind;
	logic [rfda_pkg::TIME_W-1:0]         arrival_time;
	logic signed [rfda_pkg::ATT_W-1:0]   attenuation;
	logic [rfda_pkg::IDX_W-1:0]          read_index;

	modport source (output valid, kind, arrival_time, attenuation, read_index, input ready);
	modport sink (input valid, kind, arrival_time, attenuation, read_index, output ready);
endinterface

interface rfda_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 status;
	logic signed [rfda_pkg::VALUE_W-1:0]  sample_value;

	modport source (output valid, status, sample_value, input ready);
	modport sink (input valid, status, sample_value, output ready);
endinterface

/* rtl/core/rir_fractional_delay_accumulator.sv */
// Top level of the fractional-delay impulse accumulator.
// Depends on rfda_pkg, rfda_if, rfda_front, rfda_queue and rfda_back.
//
// Usage:
//   item_in carries kind, arrival_time, attenuation and read_index; every
//   accepted transaction yields exactly one transaction on result_out
//   (status, sample_value). cfg_we/cfg_data write sample_rate; the user is
//   to write it only while idle, the block itself does not enforce this.
//   Add: one store read-modify-write per cycle through a five-stage tap
//   pipeline on the single store write port; the back end takes no new
//   command until the last result is in the result register. Clear: a
//   store sweep, one entry a cycle. After reset the store is swept to zero;
//   item_in ready stays low over that time, configuration writes are still
//   taken. A stalled receiver holds the result register; the front end and
//   a two-entry command queue keep accepting transactions until full.
module rir_fractional_delay_accumulator #(
	parameter int RESPONSE_LEN = rfda_pkg::RESPONSE_LEN_DEF,
	parameter int FILTER_LEN   = rfda_pkg::FILTER_LEN_DEF,
	parameter int LUT_STEPS    = rfda_pkg::LUT_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rfda_pkg::RATE_W-1:0]  cfg_data,
	rfda_in_if.sink                      item_in,
	rfda_out_if.source                   result_out
);

	logic           init_done;
	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	rfda_pkg::cmd_t push_cmd;
	rfda_pkg::cmd_t pop_cmd;

	rfda_front #(
		.RESPONSE_LEN (RESPONSE_LEN),
		.FILTER_LEN   (FILTER_LEN),
		.LUT_STEPS    (LUT_STEPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.init_done (init_done),
		.item      (item_in),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	rfda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	rfda_back #(
		.RESPONSE_LEN (RESPONSE_LEN),
		.FILTER_LEN   (FILTER_LEN),
		.LUT_STEPS    (LUT_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.init_done (init_done),
		.res       (result_out)
	);

endmodule

/* rtl/core/rfda_front.sv */
// Front end: accepts items, scales arrival time by the sample rate, classifies.
// Emits one back-end command per item. Depends on rfda_pkg and rfda_if.
module rfda_front #(
	parameter int RESPONSE_LEN = rfda_pkg::RESPONSE_LEN_DEF,
	parameter int FILTER_LEN   = rfda_pkg::FILTER_LEN_DEF,
	parameter int LUT_STEPS    = rfda_pkg::LUT_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfda_pkg::RATE_W-1:0]   cfg_data,
	input  logic                          init_done,
	rfda_in_if.sink                       item,
	input  logic                          q_full,
	output logic                          q_push,
	output rfda_pkg::cmd_t                q_cmd
);

	localparam int CTR = (FILTER_LEN - 1) / 2;
	localparam int PW  = rfda_pkg::TIME_W + rfda_pkg::RATE_W;
	localparam int CW  = 24;
	localparam int XW  = 38;

	logic [rfda_pkg::RATE_W-1:0]       sample_rate_q;
	logic                              vld_s1;
	logic [PW-1:0]                     p_s1;
	rfda_pkg::kind_t                   kind_s1;
	logic signed [rfda_pkg::ATT_W-1:0] att_s1;
	logic [rfda_pkg::IDX_W-1:0]        idx_s1;
	logic                              vld_s2;
	rfda_pkg::cmd_t                    cmd_s2;
	rfda_pkg::cmd_t                    cmd_d;
	logic                              adv1;
	logic                              accept;
	logic [CW-1:0]                     ip;
	logic [rfda_pkg::FRAC_W-1:0]       fr;
	logic                              rej;
	logic [XW-1:0]                     x;

	assign q_push = vld_s2 && !q_full;
	assign adv1   = vld_s1 && (!vld_s2 || q_push);
	assign item.ready = init_done && (!vld_s1 || adv1);
	assign accept = item.valid && item.ready;
	assign q_cmd  = cmd_s2;

	always_comb begin
		ip  = CW'(p_s1[PW-1:rfda_pkg::FRAC_W]);
		fr  = p_s1[rfda_pkg::FRAC_W-1:0];
		rej = (ip < CW'(CTR)) ||
			(ip + CW'(fr != '0) + CW'(CTR) >= CW'(RESPONSE_LEN)) ||
			(ip - CW'(CTR) + CW'(FILTER_LEN - 1) >= CW'(RESPONSE_LEN));
		x = XW'(29'h1000_0000 - 29'(fr)) * XW'(LUT_STEPS);
		cmd_d.base = rfda_pkg::BASE_W'(ip - CW'(CTR));
		cmd_d.pos  = x[rfda_pkg::FRAC_W +: rfda_pkg::POS_W];
		cmd_d.wt   = x[rfda_pkg::FRAC_W-1:0];
		cmd_d.att  = att_s1;
		cmd_d.idx  = idx_s1;
		unique case (kind_s1)
			rfda_pkg::KIND_ADD:   cmd_d.op = rej ? rfda_pkg::OP_REJECT : rfda_pkg::OP_ADD;
			rfda_pkg::KIND_READ:  cmd_d.op = (CW'(idx_s1) < CW'(RESPONSE_LEN)) ?
				rfda_pkg::OP_READ : rfda_pkg::OP_NOP;
			rfda_pkg::KIND_CLEAR: cmd_d.op = rfda_pkg::OP_CLEAR;
			default:              cmd_d.op = rfda_pkg::OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= rfda_pkg::RATE_RESET;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg_we) begin
				sample_rate_q <= cfg_data;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv1) begin
				vld_s1 <= 1'b0;
			end
			if (adv1) begin
				vld_s2 <= 1'b1;
			end else if (q_push) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1    <= PW'(item.arrival_time) * PW'(sample_rate_q);
			kind_s1 <= rfda_pkg::kind_t'(item.kind);
			att_s1  <= item.attenuation;
			idx_s1  <= item.read_index;
		end
		if (adv1) begin
			cmd_s2 <= cmd_d;
		end
	end

endmodule

/* rtl/core/rfda_queue.sv */
// Short command queue between front and back ends.
// Depends on rfda_pkg for the command type.
module rfda_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rfda_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output rfda_pkg::cmd_t  pop_cmd,
	output logic            empty
);

	localparam int DEPTH = rfda_pkg::QUEUE_DEPTH;
	localparam int QPW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rfda_pkg::cmd_t  fifo_q [DEPTH];
	logic [QPW-1:0]  wptr_q;
	logic [QPW-1:0]  rptr_q;
	logic [QPW:0]    cnt_q;

	assign full    = cnt_q == (QPW+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_cmd = fifo_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/core/rfda_back.sv */
// Back end: tap pipeline with sinc and window ROMs, response store, clear sweep.
// Drives the result channel. Depends on rfda_pkg and rfda_if.
module rfda_back #(
	parameter int RESPONSE_LEN = rfda_pkg::RESPONSE_LEN_DEF,
	parameter int FILTER_LEN   = rfda_pkg::FILTER_LEN_DEF,
	parameter int LUT_STEPS    = rfda_pkg::LUT_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  rfda_pkg::cmd_t  q_cmd,
	output logic            q_pop,
	output logic            init_done,
	rfda_out_if.source      res
);

	localparam int AW         = $clog2(RESPONSE_LEN);
	localparam int KW         = $clog2(FILTER_LEN);
	localparam int CTR        = (FILTER_LEN - 1) / 2;
	localparam int SINC_DEPTH = (FILTER_LEN + 2) * LUT_STEPS;
	localparam int SAW        = $clog2(SINC_DEPTH);
	localparam longint PI     = rfda_pkg::PI_Q30;
	localparam longint ONE30  = 64'd1 << 30;

	logic signed [17:0] sinc_rom [SINC_DEPTH];
	logic [16:0]        win_rom [FILTER_LEN];

	for (genvar gi = 0; gi < SINC_DEPTH; gi++) begin : g_sinc
		localparam longint M   = longint'(gi) - longint'(CTR + 1) * longint'(LUT_STEPS);
		localparam longint AM  = (M < 0) ? -M : M;
		localparam longint L   = LUT_STEPS;
		localparam longint R0  = AM % (2 * L);
		localparam bit     NEG = R0 >= L;
		localparam longint R1  = R0 % L;
		localparam longint R   = (2 * R1 > L) ? L - R1 : R1;
		localparam longint X   = (PI * R * 2 + L) / (2 * L);
		localparam longint T1  = ((((X * X) >> 30) * X) >> 30) / 6;
		localparam longint T2  = ((((T1 * X) >> 30) * X) >> 30) / 20;
		localparam longint T3  = ((((T2 * X) >> 30) * X) >> 30) / 42;
		localparam longint T4  = ((((T3 * X) >> 30) * X) >> 30) / 72;
		localparam longint T5  = ((((T4 * X) >> 30) * X) >> 30) / 110;
		localparam longint SM  = X - T1 + T2 - T3 + T4 - T5;
		localparam longint S   = (SM < 0) ? 0 : ((SM > ONE30) ? ONE30 : SM);
		localparam longint NUM = (S << 17) * L;
		localparam longint DEN = (AM == 0) ? 1 : PI * AM;
		localparam longint QM  = (NUM + DEN / 2) / DEN;
		localparam longint QS  = NEG ? -QM : QM;
		localparam longint QC  = (AM == 0) ? 131071 :
			((QS > 131071) ? 131071 : ((QS < -131072) ? -131072 : QS));
		assign sinc_rom[gi] = 18'(QC);
	end

	for (genvar gk = 0; gk < FILTER_LEN; gk++) begin : g_win
		localparam longint W   = FILTER_LEN - 1;
		localparam longint R   = (2 * gk > W) ? W - gk : longint'(gk);
		localparam longint X   = (PI * R * 2 + W) / (2 * W);
		localparam longint T1  = ((((X * X) >> 30) * X) >> 30) / 6;
		localparam longint T2  = ((((T1 * X) >> 30) * X) >> 30) / 20;
		localparam longint T3  = ((((T2 * X) >> 30) * X) >> 30) / 42;
		localparam longint T4  = ((((T3 * X) >> 30) * X) >> 30) / 72;
		localparam longint T5  = ((((T4 * X) >> 30) * X) >> 30) / 110;
		localparam longint SM  = X - T1 + T2 - T3 + T4 - T5;
		localparam longint S   = (SM < 0) ? 0 : ((SM > ONE30) ? ONE30 : SM);
		localparam longint H   = (S * S + (64'd1 << 43)) >> 44;
		localparam longint HC  = (H > 65536) ? 65536 : H;
		assign win_rom[gk] = 17'(HC);
	end

	rfda_pkg::state_t state_q, state_d;
	rfda_pkg::cmd_t   cmd_q;
	logic [KW-1:0]    k_q;
	logic [SAW-1:0]   q_q;
	logic [SAW-1:0]   q1;
	logic [AW-1:0]    a_q;
	logic [AW-1:0]    clr_q;
	logic             res_status_q;
	logic signed [31:0] res_value_q;
	logic             out_valid_q;
	logic             out_status_q;
	logic signed [31:0] out_value_q;
	logic             load_out;

	logic signed [31:0] store_q [RESPONSE_LEN];
	logic signed [31:0] rdata_q;
	logic               mem_we;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic signed [31:0] wdata;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [17:0] rom0_s1, rom1_s1;
	logic [16:0]        win_s1;
	logic [AW-1:0]      addr_s1, addr_s2, addr_s3, addr_s4, addr_s5;
	logic signed [18:0] d_s2;
	logic signed [17:0] s0_s2, s0_s3;
	logic signed [37:0] aw_s2, aw_s3, aw_s4;
	logic signed [47:0] wd_s3;
	logic signed [19:0] v_s4;
	logic signed [57:0] tp_s5;

	logic signed [17:0] win_sx;
	logic signed [28:0] wt_sx;
	logic [47:0]        mag1, r1w;
	logic signed [19:0] rnd1;
	logic [57:0]        mag2, r2w;
	logic signed [32:0] tap;
	logic signed [33:0] sum;
	logic signed [31:0] sat;
	logic               last_clr;
	logic               pipe_busy;

	assign init_done = state_q != rfda_pkg::ST_INIT;
	assign last_clr  = clr_q == AW'(RESPONSE_LEN - 1);
	assign pipe_busy = vld_s1 || vld_s2 || vld_s3 || vld_s4 || vld_s5;
	assign load_out  = (state_q == rfda_pkg::ST_DONE) && (!out_valid_q || res.ready);
	assign res.valid = out_valid_q;
	assign res.status = out_status_q;
	assign res.sample_value = out_value_q;
	assign q1     = q_q + SAW'(1);
	assign win_sx = {1'b0, win_s1};
	assign wt_sx  = {1'b0, cmd_q.wt};

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			rfda_pkg::ST_INIT: begin
				if (last_clr) state_d = rfda_pkg::ST_IDLE;
			end
			rfda_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						rfda_pkg::OP_ADD:   state_d = rfda_pkg::ST_TAPS;
						rfda_pkg::OP_READ:  state_d = rfda_pkg::ST_READ;
						rfda_pkg::OP_CLEAR: state_d = rfda_pkg::ST_CLEAR;
						default:            state_d = rfda_pkg::ST_DONE;
					endcase
				end
			end
			rfda_pkg::ST_CLEAR: begin
				if (last_clr) state_d = rfda_pkg::ST_DONE;
			end
			rfda_pkg::ST_TAPS: begin
				if (k_q == KW'(FILTER_LEN - 1)) state_d = rfda_pkg::ST_DRAIN;
			end
			rfda_pkg::ST_DRAIN: begin
				if (!pipe_busy) state_d = rfda_pkg::ST_DONE;
			end
			rfda_pkg::ST_READ:   state_d = rfda_pkg::ST_RDWAIT;
			rfda_pkg::ST_RDWAIT: state_d = rfda_pkg::ST_DONE;
			rfda_pkg::ST_DONE: begin
				if (load_out) state_d = rfda_pkg::ST_IDLE;
			end
			default: state_d = rfda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mag1 = wd_s3[47] ? 48'(-wd_s3) : 48'(wd_s3);
		r1w  = (mag1 + (48'd1 << 27)) >> 28;
		rnd1 = wd_s3[47] ? -signed'(20'(r1w)) : signed'(20'(r1w));
		mag2 = tp_s5[57] ? 58'(-tp_s5) : 58'(tp_s5);
		r2w  = (mag2 + (58'd1 << 32)) >> 33;
		tap  = tp_s5[57] ? -signed'(33'(r2w)) : signed'(33'(r2w));
		sum  = 34'(rdata_q) + 34'(tap);
		if (sum[33] != sum[31] || sum[33] != sum[32]) begin
			sat = sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat = sum[31:0];
		end
		mem_we = vld_s5 || state_q == rfda_pkg::ST_INIT || state_q == rfda_pkg::ST_CLEAR;
		waddr  = vld_s5 ? addr_s5 : clr_q;
		wdata  = vld_s5 ? sat : '0;
		raddr  = (state_q == rfda_pkg::ST_READ) ? AW'(cmd_q.idx) : addr_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rfda_pkg::ST_INIT;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= state_q == rfda_pkg::ST_TAPS;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			if (state_q == rfda_pkg::ST_INIT || state_q == rfda_pkg::ST_CLEAR) begin
				clr_q <= last_clr ? '0 : clr_q + 1'b1;
			end
			if (q_pop) begin
				k_q <= '0;
			end else if (state_q == rfda_pkg::ST_TAPS) begin
				k_q <= k_q + 1'b1;
			end
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q        <= q_cmd;
			q_q          <= SAW'(q_cmd.pos);
			a_q          <= AW'(q_cmd.base);
			res_status_q <= q_cmd.op == rfda_pkg::OP_REJECT;
			res_value_q  <= '0;
		end else if (state_q == rfda_pkg::ST_TAPS) begin
			q_q <= q_q + SAW'(LUT_STEPS);
			a_q <= a_q + 1'b1;
		end
		if (state_q == rfda_pkg::ST_RDWAIT) begin
			res_value_q <= rdata_q;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end
		rom0_s1 <= sinc_rom[q_q];
		rom1_s1 <= sinc_rom[q1];
		win_s1  <= win_rom[k_q];
		addr_s1 <= a_q;
		d_s2    <= 19'(rom1_s1) - 19'(rom0_s1);
		s0_s2   <= rom0_s1;
		aw_s2   <= cmd_q.att * win_sx;
		addr_s2 <= addr_s1;
		wd_s3   <= wt_sx * d_s2;
		s0_s3   <= s0_s2;
		aw_s3   <= aw_s2;
		addr_s3 <= addr_s2;
		v_s4    <= 20'(s0_s3) + rnd1;
		aw_s4   <= aw_s3;
		addr_s4 <= addr_s3;
		tp_s5   <= aw_s4 * v_s4;
		addr_s5 <= addr_s4;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfda_pkg::ST_IDLE) |-> !mem_we)
		else $error("store written while idle");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rfda_pkg::ST_DONE))
		else $error("result raised outside completion");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfda_pkg::ST_DONE) |-> !pipe_busy)
		else $error("completion with taps in flight");

endmodule
